/* rtl/core/suffix_automaton_common_substring_assert.svh */
`ifndef SUFFIX_AUTOMATON_COMMON_SUBSTRING_ASSERT_SVH
`define SUFFIX_AUTOMATON_COMMON_SUBSTRING_ASSERT_SVH

// Same-cycle implication under the asynchronous reset.
`define SAC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sac assertion failed");

// Next-cycle implication under the asynchronous reset.
`define SAC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sac assertion failed");

`endif

/* rtl/core/sac_pkg.sv */
package sac_pkg;

    localparam int FUNC_W    = 2;
    localparam int SYM_W     = 5;
    localparam int LEN_OUT_W = 12;

    localparam int MAX_TEXT_DEF   = 4095;
    localparam int MAX_STATES_DEF = 8192;
    localparam int ALPHABET_DEF   = 26;

    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MATCH   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] match_len;
        logic [LEN_OUT_W-1:0] best_len;
        logic                 text_full;
    } sac_res_t;

endpackage

/* rtl/core/sac_ram.sv */
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sac_ctrl.sv */
module sac_ctrl #(
    parameter int MAX_TEXT   = 4095,
    parameter int MAX_STATES = 8192,
    parameter int ALPHABET   = 26
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sac_pkg::FUNC_W-1:0]        func,
    input  logic [sac_pkg::SYM_W-1:0]         symbol,
    output logic                              res_valid,
    input  logic                              res_ready,
    output sac_pkg::sac_res_t                 res,
    output logic                              e_we,
    output logic [$clog2(MAX_STATES)-1:0]     e_waddr,
    output logic [ALPHABET*$clog2(MAX_STATES)-1:0] e_wdata,
    input  logic [ALPHABET*$clog2(MAX_STATES)-1:0] e_rdata,
    output logic                              n_we,
    output logic [$clog2(MAX_STATES)-1:0]     n_waddr,
    output logic [$clog2(MAX_TEXT+1)+$clog2(MAX_STATES)-1:0] n_wdata,
    input  logic [$clog2(MAX_TEXT+1)+$clog2(MAX_STATES)-1:0] n_rdata,
    output logic [$clog2(MAX_STATES)-1:0]     raddr
);
    import sac_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int LW = $clog2(MAX_TEXT + 1);
    localparam int KW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam logic [SW-1:0] ROOT = SW'(1);
    localparam logic [SW-1:0] NONE = '0;

    typedef logic [ALPHABET-1:0][SW-1:0] row_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_INIT, S_A_CHK, S_A_Q, S_A_R, S_A_RC, S_A_FIN,
        S_M_CHK, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [SW-1:0]   last_reg, last_next;
    logic [SW-1:0]   count_reg, count_next;
    logic [LW-1:0]   tlen_reg, tlen_next;
    logic [SW-1:0]   mstate_reg, mstate_next;
    logic [LW-1:0]   mlen_reg, mlen_next;
    logic [LW-1:0]   best_reg, best_next;
    logic [SW-1:0]   p_reg, p_next;
    logic [SW-1:0]   np_reg, np_next;
    logic [SW-1:0]   q_reg, q_next;
    logic [SW-1:0]   flink_reg, flink_next;
    logic            clone_reg, clone_next;
    logic            from_link_reg, from_link_next;
    logic [LW-1:0]   lenp_reg, lenp_next;
    logic [LW-1:0]   lenq_reg, lenq_next;
    logic [SW-1:0]   linkp_reg, linkp_next;
    row_t            rowp_reg, rowp_next;
    sac_res_t        res_reg, res_next;

    row_t            rd_row;
    row_t            wr_row;
    logic [LW-1:0]   rd_len;
    logic [SW-1:0]   rd_link;
    logic [SW-1:0]   rd_edge;
    logic            sym_ok;
    logic            room_low;
    logic [LW-1:0]   cur_len;
    logic [LW-1:0]   new_len;

    assign rd_row   = row_t'(e_rdata);
    assign rd_len   = n_rdata[LW+SW-1:SW];
    assign rd_link  = n_rdata[SW-1:0];
    assign rd_edge  = rd_row[k_reg];
    assign sym_ok   = 32'(symbol) < ALPHABET;
    assign room_low = ((SW+1)'(count_reg) + (SW+1)'(2)) > (SW+1)'(MAX_STATES - 1);
    assign cur_len  = from_link_reg ? rd_len : mlen_reg;
    assign new_len  = cur_len + LW'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        tlen_next      = tlen_reg;
        mstate_next    = mstate_reg;
        mlen_next      = mlen_reg;
        best_next      = best_reg;
        p_next         = p_reg;
        np_next        = np_reg;
        q_next         = q_reg;
        flink_next     = flink_reg;
        clone_next     = clone_reg;
        from_link_next = from_link_reg;
        lenp_next      = lenp_reg;
        lenq_next      = lenq_reg;
        linkp_next     = linkp_reg;
        rowp_next      = rowp_reg;
        res_next       = res_reg;
        e_we           = 1'b0;
        e_waddr        = np_reg;
        wr_row         = '0;
        n_we           = 1'b0;
        n_waddr        = np_reg;
        n_wdata        = '0;
        raddr          = p_reg;

        unique case (state_reg)
            S_INIT:
            begin
                // Root gets no edges, length zero and no link.
                e_we       = 1'b1;
                e_waddr    = ROOT;
                n_we       = 1'b1;
                n_waddr    = ROOT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    k_next   = KW'(symbol);
                    res_next = '0;
                    unique case (func)
                        FUNC_APPEND:
                        begin
                            mstate_next = ROOT;
                            mlen_next   = '0;
                            best_next   = '0;
                            if (!sym_ok)
                            begin
                                state_next = S_DONE;
                            end
                            else if (tlen_reg >= LW'(MAX_TEXT) || room_low)
                            begin
                                res_next.text_full = 1'b1;
                                state_next         = S_DONE;
                            end
                            else
                            begin
                                np_next    = count_reg + SW'(1);
                                p_next     = last_reg;
                                clone_next = 1'b0;
                                state_next = S_A_INIT;
                            end
                        end
                        FUNC_MATCH:
                        begin
                            if (!sym_ok)
                            begin
                                mstate_next       = ROOT;
                                mlen_next         = '0;
                                res_next.best_len = LEN_OUT_W'(best_reg);
                                state_next        = S_DONE;
                            end
                            else
                            begin
                                raddr          = mstate_reg;
                                from_link_next = 1'b0;
                                state_next     = S_M_CHK;
                            end
                        end
                        FUNC_RESTART:
                        begin
                            mstate_next = ROOT;
                            mlen_next   = '0;
                            best_next   = '0;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            res_next.match_len = LEN_OUT_W'(mlen_reg);
                            res_next.best_len  = LEN_OUT_W'(best_reg);
                            state_next         = S_DONE;
                        end
                    endcase
                end
            end
            S_A_INIT:
            begin
                e_we       = 1'b1;
                e_waddr    = np_reg;
                raddr      = p_reg;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                rowp_next  = rd_row;
                lenp_next  = rd_len;
                linkp_next = rd_link;
                if (rd_edge == NONE)
                begin
                    e_we           = 1'b1;
                    e_waddr        = p_reg;
                    wr_row         = rd_row;
                    wr_row[k_reg]  = np_reg;
                    if (rd_link == NONE)
                    begin
                        flink_next = ROOT;
                        state_next = S_A_FIN;
                    end
                    else
                    begin
                        p_next = rd_link;
                        raddr  = rd_link;
                    end
                end
                else
                begin
                    q_next     = rd_edge;
                    raddr      = rd_edge;
                    state_next = S_A_Q;
                end
            end
            S_A_Q:
            begin
                if (rd_len == lenp_reg + LW'(1))
                begin
                    flink_next = q_reg;
                    state_next = S_A_FIN;
                end
                else
                begin
                    // Clone q into the next free state and redirect edges to it.
                    e_we       = 1'b1;
                    e_waddr    = np_reg + SW'(1);
                    wr_row     = rd_row;
                    n_we       = 1'b1;
                    n_waddr    = np_reg + SW'(1);
                    n_wdata    = {lenp_reg + LW'(1), rd_link};
                    lenq_next  = rd_len;
                    flink_next = np_reg + SW'(1);
                    clone_next = 1'b1;
                    state_next = S_A_R;
                end
            end
            S_A_R:
            begin
                e_we          = 1'b1;
                e_waddr       = p_reg;
                wr_row        = rowp_reg;
                wr_row[k_reg] = flink_reg;
                n_we          = 1'b1;
                n_waddr       = q_reg;
                n_wdata       = {lenq_reg, flink_reg};
                p_next        = linkp_reg;
                raddr         = linkp_reg;
                state_next    = (linkp_reg == NONE) ? S_A_FIN : S_A_RC;
            end
            S_A_RC:
            begin
                if (rd_edge == q_reg)
                begin
                    e_we          = 1'b1;
                    e_waddr       = p_reg;
                    wr_row        = rd_row;
                    wr_row[k_reg] = flink_reg;
                    p_next        = rd_link;
                    raddr         = rd_link;
                    if (rd_link == NONE)
                    begin
                        state_next = S_A_FIN;
                    end
                end
                else
                begin
                    state_next = S_A_FIN;
                end
            end
            S_A_FIN:
            begin
                n_we       = 1'b1;
                n_waddr    = np_reg;
                n_wdata    = {tlen_reg + LW'(1), flink_reg};
                last_next  = np_reg;
                tlen_next  = tlen_reg + LW'(1);
                count_next = clone_reg ? np_reg + SW'(1) : np_reg;
                state_next = S_DONE;
            end
            S_M_CHK:
            begin
                if (rd_edge != NONE)
                begin
                    mstate_next        = rd_edge;
                    mlen_next          = new_len;
                    best_next          = (new_len > best_reg) ? new_len : best_reg;
                    res_next.match_len = LEN_OUT_W'(new_len);
                    res_next.best_len  = LEN_OUT_W'((new_len > best_reg) ? new_len : best_reg);
                    state_next         = S_DONE;
                end
                else if (rd_link == NONE)
                begin
                    mstate_next       = ROOT;
                    mlen_next         = '0;
                    res_next.best_len = LEN_OUT_W'(best_reg);
                    state_next        = S_DONE;
                end
                else
                begin
                    // Fall back along the suffix link; its length arrives with the read.
                    raddr          = rd_link;
                    from_link_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        e_wdata = wr_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            last_reg      <= ROOT;
            count_reg     <= ROOT;
            tlen_reg      <= '0;
            mstate_reg    <= ROOT;
            mlen_reg      <= '0;
            best_reg      <= '0;
            clone_reg     <= 1'b0;
            from_link_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            tlen_reg      <= tlen_next;
            mstate_reg    <= mstate_next;
            mlen_reg      <= mlen_next;
            best_reg      <= best_next;
            clone_reg     <= clone_next;
            from_link_reg <= from_link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        p_reg     <= p_next;
        np_reg    <= np_next;
        q_reg     <= q_next;
        flink_reg <= flink_next;
        lenp_reg  <= lenp_next;
        lenq_reg  <= lenq_next;
        linkp_reg <= linkp_next;
        rowp_reg  <= rowp_next;
        res_reg   <= res_next;
    end

endmodule

/* rtl/core/suffix_automaton_common_substring.sv */
// Restart, the unused code, bad symbols and refused appends go straight to the result. A match
// reads the current state, then follows suffix links until an edge is found or the links run out.
// An append clears the new state and walks the suffix links adding edges, reads the target where
// the walk stops at an edge, and for a clone redirects edges state by state, then links the state.
// One item is in work at a time; the next is taken once its result is in the output register.
// Reset clears control state; the root entry is written in the first cycle after it.
module suffix_automaton_common_substring #(
    parameter int MAX_TEXT   = sac_pkg::MAX_TEXT_DEF,
    parameter int MAX_STATES = sac_pkg::MAX_STATES_DEF,
    parameter int ALPHABET   = sac_pkg::ALPHABET_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sac_pkg::FUNC_W-1:0]        func,
    input  logic [sac_pkg::SYM_W-1:0]         symbol,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sac_pkg::LEN_OUT_W-1:0]     match_len,
    output logic [sac_pkg::LEN_OUT_W-1:0]     best_len,
    output logic                              text_full
);
    import sac_pkg::*;
    `include "suffix_automaton_common_substring_assert.svh"

    localparam int SW = $clog2(MAX_STATES);
    localparam int LW = $clog2(MAX_TEXT + 1);
    localparam int EW = ALPHABET * SW;

    logic           res_valid;
    logic           res_ready;
    sac_res_t       res;
    sac_res_t       out_reg;
    logic           out_valid_reg, out_valid_next;
    logic           e_we, n_we;
    logic [SW-1:0]  e_waddr, n_waddr, raddr;
    logic [EW-1:0]  e_wdata, e_rdata;
    logic [LW+SW-1:0] n_wdata, n_rdata;

    sac_ctrl #(
        .MAX_TEXT   (MAX_TEXT),
        .MAX_STATES (MAX_STATES),
        .ALPHABET   (ALPHABET)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .symbol    (symbol),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .e_we      (e_we),
        .e_waddr   (e_waddr),
        .e_wdata   (e_wdata),
        .e_rdata   (e_rdata),
        .n_we      (n_we),
        .n_waddr   (n_waddr),
        .n_wdata   (n_wdata),
        .n_rdata   (n_rdata),
        .raddr     (raddr)
    );

    sac_ram #(.WIDTH(EW), .DEPTH(MAX_STATES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (raddr),
        .rdata (e_rdata)
    );

    sac_ram #(.WIDTH(LW + SW), .DEPTH(MAX_STATES)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (raddr),
        .rdata (n_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign match_len = out_reg.match_len;
    assign best_len  = out_reg.best_len;
    assign text_full = out_reg.text_full;

    // One item in work at a time.
    `SAC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    // A refused append reports no match.
    `SAC_ASSERT_IMP(a_full_no_match, clk, rst_n, out_valid && text_full, (match_len | best_len) == '0)
    // The running best never trails the current match.
    `SAC_ASSERT_IMP(a_best_covers, clk, rst_n, out_valid, best_len >= match_len)

endmodule

/* verif/suffix_automaton_common_substring_tb.sv */
`timescale 1ns / 100ps

module suffix_automaton_common_substring_tb;
    import sac_pkg::*;

    localparam int TEXT_CAP   = MAX_TEXT_DEF;
    localparam int STATE_CAP  = MAX_STATES_DEF;
    localparam int SIGMA      = ALPHABET_DEF;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func = FUNC_RESTART;
    logic [SYM_W-1:0]     symbol = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LEN_OUT_W-1:0] match_len;
    logic [LEN_OUT_W-1:0] best_len;
    logic                 text_full;

    suffix_automaton_common_substring dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .symbol(symbol),
        .out_valid(out_valid), .out_ready(out_ready),
        .match_len(match_len), .best_len(best_len), .text_full(text_full)
    );

    always #2 clk = ~clk;

    // Shadow automaton.
    int unsigned trans [STATE_CAP][SIGMA];
    int unsigned node_len [STATE_CAP];
    int unsigned node_link [STATE_CAP];
    int unsigned tail_node, node_total, cur_node, cur_len, top_len;

    sac_res_t lcs_expected [$];
    int errors = 0;
    int beats_out = 0;
    longint cycles = 0;

    function automatic void clear_tracking();
        cur_node = 1;
        cur_len = 0;
        top_len = 0;
    endfunction

    function automatic bit extend_text(int unsigned k);
        int unsigned p, np, q, nq;
        if (node_len[tail_node] >= TEXT_CAP || node_total + 2 > STATE_CAP - 1)
            return 1'b1;
        p = tail_node;
        node_total++;
        np = node_total;
        for (int c = 0; c < SIGMA; c++)
            trans[np][c] = 0;
        node_len[np] = node_len[p] + 1;
        while (p != 0 && trans[p][k] == 0)
        begin
            trans[p][k] = np;
            p = node_link[p];
        end
        if (p == 0)
            node_link[np] = 1;
        else
        begin
            q = trans[p][k];
            if (node_len[q] == node_len[p] + 1)
                node_link[np] = q;
            else
            begin
                node_total++;
                nq = node_total;
                for (int c = 0; c < SIGMA; c++)
                    trans[nq][c] = trans[q][c];
                node_link[nq] = node_link[q];
                node_len[nq] = node_len[p] + 1;
                node_link[q] = nq;
                node_link[np] = nq;
                while (p != 0 && trans[p][k] == q)
                begin
                    trans[p][k] = nq;
                    p = node_link[p];
                end
            end
        end
        tail_node = np;
        return 1'b0;
    endfunction

    function automatic sac_res_t predict_lcs(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s);
        sac_res_t r;
        bit legal;
        int unsigned p, len;
        r = '0;
        legal = (s < SIGMA);
        if (f == FUNC_APPEND)
        begin
            if (legal && extend_text(s))
                r.text_full = 1'b1;
            clear_tracking();
        end
        else if (f == FUNC_MATCH)
        begin
            p = legal ? cur_node : 0;
            len = cur_len;
            if (legal)
            begin
                while (p != 0 && trans[p][s] == 0)
                begin
                    p = node_link[p];
                    len = node_len[p];
                end
            end
            if (p != 0)
            begin
                len++;
                p = trans[p][s];
            end
            else
            begin
                p = 1;
                len = 0;
            end
            cur_node = p;
            cur_len = len;
            if (len > top_len)
                top_len = len;
        end
        else if (f == FUNC_RESTART)
            clear_tracking();
        if (f == FUNC_MATCH || f == FUNC_UNUSED)
        begin
            r.match_len = cur_len[LEN_OUT_W-1:0];
            r.best_len = top_len[LEN_OUT_W-1:0];
        end
        return r;
    endfunction

    // Valid drops only when a gap follows, so back-to-back beats keep it high.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sends one beat; a typed expectation overrides the prediction in the check queue.
    task automatic send_item(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s,
                             bit typed, sac_res_t want);
        sac_res_t r;
        r = predict_lcs(f, s);
        if (typed && r !== want)
        begin
            $error("directed row disagrees with predictor: expected %h got %h", want, r);
            errors++;
        end
        lcs_expected.push_back(typed ? want : r);
        in_valid <= 1'b1;
        func <= f;
        symbol <= s;
        do @(posedge clk); while (!in_ready);
        idle_gap();
    endtask

    // Consumer side with random stalls.
    always @(posedge clk)
    begin
        sac_res_t e;
        cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (lcs_expected.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = lcs_expected.pop_front();
                if (match_len !== e.match_len)
                begin
                    $error("match_len: expected %0d actual %0d", e.match_len, match_len);
                    errors++;
                end
                if (best_len !== e.best_len)
                begin
                    $error("best_len: expected %0d actual %0d", e.best_len, best_len);
                    errors++;
                end
                if (text_full !== e.text_full)
                begin
                    $error("text_full: expected %0d actual %0d", e.text_full, text_full);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("suffix_automaton_common_substring: mismatch");
            $finish;
        end
    end

    typedef struct {
        logic [FUNC_W-1:0] f;
        logic [SYM_W-1:0]  s;
        bit                typed;
        sac_res_t          want;
    } stim_row_t;

    stim_row_t plan [] = '{
        '{FUNC_MATCH,   5'd0,  1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_UNUSED,  5'd31, 1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd0,  1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd1,  1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd0,  1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd1,  1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd1,  1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd25, 1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd26, 1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_APPEND,  5'd31, 1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_MATCH,   5'd0,  1'b1, '{12'd1, 12'd1, 1'b0}},
        '{FUNC_MATCH,   5'd1,  1'b0, '0},
        '{FUNC_MATCH,   5'd0,  1'b0, '0},
        '{FUNC_MATCH,   5'd1,  1'b0, '0},
        '{FUNC_MATCH,   5'd1,  1'b0, '0},
        '{FUNC_UNUSED,  5'd0,  1'b0, '0},
        '{FUNC_MATCH,   5'd7,  1'b0, '0},
        '{FUNC_MATCH,   5'd25, 1'b0, '0},
        '{FUNC_MATCH,   5'd30, 1'b0, '0},
        '{FUNC_UNUSED,  5'd0,  1'b0, '0},
        '{FUNC_RESTART, 5'd31, 1'b1, '{12'd0, 12'd0, 1'b0}},
        '{FUNC_MATCH,   5'd1,  1'b0, '0},
        '{FUNC_MATCH,   5'd26, 1'b1, '{12'd0, 12'd1, 1'b0}}
    };

    function automatic logic [SYM_W-1:0] pick_symbol(int sigma);
        if ($urandom_range(0, 39) == 0)
            return SYM_W'($urandom_range(SIGMA, 31));
        return SYM_W'($urandom_range(0, sigma - 1));
    endfunction

    initial
    begin
        int sigma, total;
        logic [FUNC_W-1:0] f;
        for (int i = 0; i < STATE_CAP; i++)
        begin
            node_len[i] = 0;
            node_link[i] = 0;
            for (int c = 0; c < SIGMA; c++)
                trans[i][c] = 0;
        end
        tail_node = 1;
        node_total = 1;
        clear_tracking();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].f, plan[i].s, plan[i].typed, plan[i].want);

        // Let everything drain once before the random part.
        in_valid <= 1'b0;
        wait (lcs_expected.size() == 0);
        @(posedge clk);

        // Mostly grow the text on a small alphabet, with match runs that share it.
        total = 0;
        while (total < 1850)
        begin
            sigma = ($urandom_range(0, 2) == 0) ? SIGMA : $urandom_range(2, 4);
            repeat ($urandom_range(3, 20))
            begin
                send_item(FUNC_APPEND, pick_symbol(sigma), 1'b0, '0);
                total++;
            end
            repeat ($urandom_range(5, 40))
            begin
                case ($urandom_range(0, 19))
                    0:       f = FUNC_RESTART;
                    1:       f = FUNC_UNUSED;
                    2:       f = FUNC_APPEND;
                    default: f = FUNC_MATCH;
                endcase
                send_item(f, pick_symbol(sigma), 1'b0, '0);
                total++;
            end
        end

        repeat (60)
            send_item($urandom_range(0, 1) ? FUNC_MATCH : FUNC_UNUSED,
                      SYM_W'($urandom_range(0, 1)), 1'b0, '0);
        send_item(FUNC_MATCH, 5'd31, 1'b0, '0);
        in_valid <= 1'b0;

        wait (lcs_expected.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d result beats: text building with clones, query walks,", beats_out);
        $display("restarts, the unused code and out-of-range symbols.");
        if (errors == 0)
            $display("suffix_automaton_common_substring: match");
        else
            $display("suffix_automaton_common_substring: mismatch");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sac_pkg.sv
rtl/core/sac_ram.sv
rtl/core/sac_ctrl.sv
rtl/core/suffix_automaton_common_substring.sv
verif/suffix_automaton_common_substring_tb.sv
